/* src/bwl_pkg.sv */
// Shared constants, register codes and types for the Butterworth low-pass weighting block.
// No dependencies; used by bwl_div and butterworth_lowpass_weighting.
`timescale 1ns / 1ps
`default_nettype none
package bwl_pkg;

  localparam int MAX_SIDE = 1024;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int DEG_MAX = 15;
  localparam int DIV_NW = 41;
  localparam int DIV_DW = 34;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DEGREE = 2'd0;
  localparam cfg_idx_t CFG_CUTOFF = 2'd1;
  localparam cfg_idx_t CFG_SIDE   = 2'd2;

  localparam logic [33:0] Q_ONE = 34'd65536;
  localparam logic [33:0] R_SAT = 34'h2_0000_0000;
  localparam logic [10:0] SIDE_LIMIT = 11'(MAX_SIDE);

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } side_t;

endpackage
`default_nettype wire

/* src/bwl_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bwl_pkg for widths and the side_t payload carried alongside.
`timescale 1ns / 1ps
`default_nettype none
module bwl_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [bwl_pkg::DIV_NW-1:0]  in_num,
  input  wire logic [bwl_pkg::DIV_DW-1:0]  in_den,
  input  wire bwl_pkg::side_t              in_side,
  output logic                             out_vld,
  output logic [bwl_pkg::DIV_NW-1:0]       out_quo,
  output bwl_pkg::side_t                   out_side
);

  localparam int NW = bwl_pkg::DIV_NW;
  localparam int DW = bwl_pkg::DIV_DW;

  logic                vld_r  [NW];
  logic [DW-1:0]       rem_r  [NW];
  logic [DW-1:0]       den_r  [NW];
  logic [NW-1:0]       quo_r  [NW];
  logic [NW-1:0]       num_r  [NW];
  bwl_pkg::side_t      side_r [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic           p_vld;
    logic [DW-1:0]  p_rem;
    logic [DW-1:0]  p_den;
    logic [NW-1:0]  p_quo;
    logic [NW-1:0]  p_num;
    bwl_pkg::side_t p_side;
    logic [DW:0]    trial;
    logic           ge;
    logic [DW-1:0]  rem_nxt;

    if (g == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_den  = in_den;
      assign p_quo  = '0;
      assign p_num  = in_num;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[g-1];
      assign p_rem  = rem_r[g-1];
      assign p_den  = den_r[g-1];
      assign p_quo  = quo_r[g-1];
      assign p_num  = num_r[g-1];
      assign p_side = side_r[g-1];
    end

    assign trial   = {p_rem, p_num[NW-1]};
    assign ge      = trial >= {1'b0, p_den};
    assign rem_nxt = ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= rem_nxt;
      den_r[g]  <= p_den;
      quo_r[g]  <= {p_quo[NW-2:0], ge};
      num_r[g]  <= {p_num[NW-2:0], 1'b0};
      side_r[g] <= p_side;
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = quo_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule
`default_nettype wire

/* src/butterworth_lowpass_weighting.sv */
// Top level: Butterworth low-pass gain applied to one complex spectrum word per cycle.
// Depends on bwl_pkg and bwl_div (two instances: ratio and weight).
//
//   channel  | handshake            | payload
//   input    | start, busy          | in_row, in_col, in_re_in, in_im_in
//   result   | out_valid (strobe)   | out_re_out, out_im_out, out_weight
//   config   | cfg_we               | cfg_idx, cfg_data
//
// One word enters every cycle; busy stays low. The path runs through the two 41-stage
// bit-per-stage dividers and the 15-stage power chain.
// Synchronous active-low reset clears valid bits and loads the register defaults.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module butterworth_lowpass_weighting (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [9:0]            in_row,
  input  wire logic [9:0]            in_col,
  input  wire logic signed [31:0]    in_re_in,
  input  wire logic signed [31:0]    in_im_in,
  output logic                       out_valid,
  output logic signed [31:0]         out_re_out,
  output logic signed [31:0]         out_im_out,
  output logic [16:0]                out_weight,
  input  wire logic                  cfg_we,
  input  wire bwl_pkg::cfg_idx_t     cfg_idx,
  input  wire logic [10:0]           cfg_data
);

  localparam int ND = bwl_pkg::DEG_MAX;
  localparam int NW = bwl_pkg::DIV_NW;
  localparam int DW = bwl_pkg::DIV_DW;

  // configuration
  logic [3:0]  deg_r;
  logic [10:0] cut_r;
  logic [10:0] side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r  <= 4'd2;
      cut_r  <= 11'd32;
      side_r <= 11'd256;
    end else if (cfg_we) begin
      case (cfg_idx)
        bwl_pkg::CFG_DEGREE: deg_r  <= cfg_data[3:0];
        bwl_pkg::CFG_CUTOFF: cut_r  <= cfg_data;
        bwl_pkg::CFG_SIDE:   side_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage a: capture word, form offsets
  logic                a_vld_r;
  logic signed [11:0]  a_du_r;
  logic signed [11:0]  a_dv_r;
  bwl_pkg::side_t      a_side_r;
  logic [10:0]         n_eff;
  logic signed [11:0]  du_nxt;
  logic signed [11:0]  dv_nxt;

  assign n_eff  = (side_r > bwl_pkg::SIDE_LIMIT) ? bwl_pkg::SIDE_LIMIT : side_r;
  assign du_nxt = $signed({1'b0, in_row, 1'b0}) - $signed({1'b0, n_eff});
  assign dv_nxt = $signed({1'b0, in_col, 1'b0}) - $signed({1'b0, n_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_du_r   <= du_nxt;
    a_dv_r   <= dv_nxt;
    a_side_r <= '{re: in_re_in, im: in_im_in};
  end

  // stage b: squares and cutoff square
  logic           b_vld_r;
  logic [22:0]    b_su_r;
  logic [22:0]    b_sv_r;
  logic [21:0]    b_c2_r;
  bwl_pkg::side_t b_side_r;
  logic [10:0]    c_eff;

  assign c_eff = (cut_r == 11'd0) ? 11'd1 : cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_su_r   <= 23'(a_du_r) * 23'(a_du_r);
    b_sv_r   <= 23'(a_dv_r) * 23'(a_dv_r);
    b_c2_r   <= c_eff * c_eff;
    b_side_r <= a_side_r;
  end

  // stage c: numerator and divisor of the ratio
  logic           c_vld_r;
  logic [NW-1:0]  c_num_r;
  logic [DW-1:0]  c_den_r;
  bwl_pkg::side_t c_side_r;
  logic [23:0]    s_sum;
  logic [23:0]    den1;

  assign s_sum = {1'b0, b_su_r} + {1'b0, b_sv_r};
  assign den1  = {b_c2_r, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_num_r  <= NW'({s_sum, 16'd0}) + NW'(den1[23:1]);
    c_den_r  <= DW'(den1);
    c_side_r <= b_side_r;
  end

  logic           d1_vld;
  logic [NW-1:0]  d1_quo;
  bwl_pkg::side_t d1_side;

  bwl_div u_div_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld_r),
    .in_num   (c_num_r),
    .in_den   (c_den_r),
    .in_side  (c_side_r),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  logic [DW-1:0] ratio;
  assign ratio = (d1_quo > NW'(bwl_pkg::R_SAT)) ? bwl_pkg::R_SAT : d1_quo[DW-1:0];

  // power chain: one saturating Q18.16 multiply per stage below the degree; later stages pass the product on
  logic           pw_vld_r  [ND];
  logic [DW-1:0]  pw_p_r    [ND];
  logic [DW-1:0]  pw_r_r    [ND];
  bwl_pkg::side_t pw_side_r [ND];

  for (genvar k = 0; k < ND; k++) begin : g_pow
    logic           p_vld;
    logic [DW-1:0]  p_p;
    logic [DW-1:0]  p_r;
    bwl_pkg::side_t p_side;
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] rnd;
    logic [DW-1:0]   p_nxt;

    if (k == 0) begin : g_first
      assign p_vld  = d1_vld;
      assign p_p    = bwl_pkg::Q_ONE;
      assign p_r    = ratio;
      assign p_side = d1_side;
    end else begin : g_next
      assign p_vld  = pw_vld_r[k-1];
      assign p_p    = pw_p_r[k-1];
      assign p_r    = pw_r_r[k-1];
      assign p_side = pw_side_r[k-1];
    end

    assign prod = p_p * p_r;
    assign rnd  = (prod + (2*DW)'(32768)) >> 16;
    assign p_nxt = (4'(k) >= deg_r) ? p_p :
                   (rnd > (2*DW)'(bwl_pkg::R_SAT)) ? bwl_pkg::R_SAT : rnd[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_vld_r[k] <= 1'b0;
      end else begin
        pw_vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      pw_p_r[k]    <= p_nxt;
      pw_r_r[k]    <= p_r;
      pw_side_r[k] <= p_side;
    end
  end

  // stage e: weight division operands
  logic           e_vld_r;
  logic [NW-1:0]  e_num_r;
  logic [DW-1:0]  e_den_r;
  bwl_pkg::side_t e_side_r;
  logic [DW-1:0]  wden;

  assign wden = pw_p_r[ND-1] + bwl_pkg::Q_ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= pw_vld_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    e_num_r  <= NW'(64'd1 << (16 + bwl_pkg::WEIGHT_FRAC_BITS)) + NW'(wden[DW-1:1]);
    e_den_r  <= wden;
    e_side_r <= pw_side_r[ND-1];
  end

  logic           d2_vld;
  logic [NW-1:0]  d2_quo;
  bwl_pkg::side_t d2_side;
  bwl_pkg::side_t d2_side_in;

  assign d2_side_in = e_side_r;

  bwl_div u_div_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e_vld_r),
    .in_num   (e_num_r),
    .in_den   (e_den_r),
    .in_side  (d2_side_in),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // stage f: magnitude times weight
  logic         f_vld_r;
  logic [48:0]  f_pre_r;
  logic [48:0]  f_pim_r;
  logic         f_nre_r;
  logic         f_nim_r;
  logic [16:0]  f_w_r;
  logic [16:0]  w_q;
  logic [31:0]  mag_re;
  logic [31:0]  mag_im;

  assign w_q    = d2_quo[16:0];
  assign mag_re = d2_side.re[31] ? 32'(-d2_side.re) : 32'(d2_side.re);
  assign mag_im = d2_side.im[31] ? 32'(-d2_side.im) : 32'(d2_side.im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    f_pre_r <= mag_re * w_q;
    f_pim_r <= mag_im * w_q;
    f_nre_r <= d2_side.re[31];
    f_nim_r <= d2_side.im[31];
    f_w_r   <= w_q;
  end

  // stage g: round, restore sign, drive result
  logic [48:0] q_re;
  logic [48:0] q_im;
  logic        out_valid_r;
  logic [31:0] out_re_r;
  logic [31:0] out_im_r;
  logic [16:0] out_w_r;

  assign q_re = (f_pre_r + 49'(1 << (bwl_pkg::WEIGHT_FRAC_BITS - 1))) >> bwl_pkg::WEIGHT_FRAC_BITS;
  assign q_im = (f_pim_r + 49'(1 << (bwl_pkg::WEIGHT_FRAC_BITS - 1))) >> bwl_pkg::WEIGHT_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_re_r <= f_nre_r ? 32'(-q_re) : q_re[31:0];
    out_im_r <= f_nim_r ? 32'(-q_im) : q_im[31:0];
    out_w_r  <= f_w_r;
  end

  assign out_valid  = out_valid_r;
  assign out_re_out = out_re_r;
  assign out_im_out = out_im_r;
  assign out_weight = out_w_r;

endmodule
`default_nettype wire

/* dv/butterworth_lowpass_weighting_tb.sv */
// Self-checking testbench for butterworth_lowpass_weighting: directed and random words,
// with the expected weight and scaled parts worked out in fixed point inside the bench.
// Depends on bwl_pkg and the RTL top level only.
`timescale 1ns / 1ps
module butterworth_lowpass_weighting_tb;

  localparam bwl_pkg::cfg_idx_t CFG_UNUSED = 2'd3;
  localparam int PIPE_DEPTH = 103;
  localparam int STALL_LIMIT = 4000;
  localparam longint unsigned SAT_Q = 64'h2_0000_0000;
  localparam longint unsigned ONE_Q = 64'd65536;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [16:0]        weight;
  } gain_word_t;

  logic clk, rst_n, start, busy;
  logic [9:0] in_row, in_col;
  logic signed [31:0] in_re_in, in_im_in;
  logic out_valid;
  logic signed [31:0] out_re_out, out_im_out;
  logic [16:0] out_weight;
  logic cfg_we;
  bwl_pkg::cfg_idx_t cfg_idx;
  logic [10:0] cfg_data;

  logic [3:0]  order_q;
  logic [10:0] cutoff_q;
  logic [10:0] side_q;
  gain_word_t  pending_gain[$];
  int          err_count;
  int          idle_pct;
  int          stall_cycles;
  bit          word_taken;

  butterworth_lowpass_weighting u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_row(in_row), .in_col(in_col), .in_re_in(in_re_in), .in_im_in(in_im_in),
    .out_valid(out_valid), .out_re_out(out_re_out), .out_im_out(out_im_out),
    .out_weight(out_weight), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned q16_product(longint unsigned a, longint unsigned b);
    longint unsigned prod;
    if (b != 0 && a > (64'hFFFF_FFFF_FFFF_FFFF - 64'd32768) / b) return SAT_Q;
    prod = (a * b + 64'd32768) >> 16;
    return (prod > SAT_Q) ? SAT_Q : prod;
  endfunction

  function automatic logic [31:0] apply_gain(logic [31:0] x, longint unsigned w);
    longint unsigned mag, q;
    bit neg;
    neg = x[31];
    mag = neg ? longint'((~x + 32'd1)) & 64'hFFFF_FFFF : longint'(x) & 64'hFFFF_FFFF;
    q = (mag * w + 64'd32768) >> 16;
    if (neg) q = ~q + 64'd1;
    return q[31:0];
  endfunction

  function automatic gain_word_t predict_gain(logic [9:0] row, logic [9:0] col,
                                              logic [31:0] re, logic [31:0] im);
    longint n, du, dv;
    longint unsigned s, c, den, r, p, wden, w;
    gain_word_t g;
    n = (side_q > bwl_pkg::SIDE_LIMIT) ? bwl_pkg::MAX_SIDE : longint'(side_q);
    du = 2 * longint'(row) - n;
    dv = 2 * longint'(col) - n;
    s = du * du + dv * dv;
    c = (cutoff_q == 0) ? 1 : longint'(cutoff_q);
    den = 4 * c * c;
    r = ((s << 16) + den / 2) / den;
    if (r > SAT_Q) r = SAT_Q;
    p = ONE_Q;
    for (int k = 0; k < order_q; k++) p = q16_product(p, r);
    wden = ONE_Q + p;
    w = ((64'd1 << 32) + wden / 2) / wden;
    g.re = apply_gain(re, w);
    g.im = apply_gain(im, w);
    g.weight = w[16:0];
    return g;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_gain.size() == 0) begin
        $error("unexpected result word: weight %0d", out_weight);
        err_count++;
      end else begin
        gain_word_t g;
        g = pending_gain.pop_front();
        if (out_re_out !== g.re) begin
          $error("re_out: expected %0d, got %0d", g.re, out_re_out);
          err_count++;
        end
        if (out_im_out !== g.im) begin
          $error("im_out: expected %0d, got %0d", g.im, out_im_out);
          err_count++;
        end
        if (out_weight !== g.weight) begin
          $error("weight: expected %0d, got %0d", g.weight, out_weight);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (word_taken || out_valid || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("butterworth_lowpass_weighting_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(bwl_pkg::cfg_idx_t idx, logic [10:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bwl_pkg::CFG_DEGREE: order_q  = data[3:0];
      bwl_pkg::CFG_CUTOFF: cutoff_q = data;
      bwl_pkg::CFG_SIDE:   side_q   = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(logic [9:0] row, logic [9:0] col, logic [31:0] re, logic [31:0] im);
    word_taken = 1'b0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start    <= 1'b1;
    in_row   <= row;
    in_col   <= col;
    in_re_in <= re;
    in_im_in <= im;
    @(posedge clk);
    while (busy) @(posedge clk);
    word_taken = 1'b1;
    pending_gain.push_back(predict_gain(row, col, re, im));
  endtask

  task automatic drain();
    start <= 1'b0;
    word_taken = 1'b0;
    while (pending_gain.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_word(10'd128, 10'd128, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(10'd160, 10'd128, 32'd1000, -32'sd1000);
    send_word(10'd0, 10'd0, 32'd65536, 32'd3);
    drain();
  endtask

  task automatic test_directed();
    send_word(10'd1023, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(10'd0, 10'd1023, 32'hFFFF_FFFF, 32'd1);
    send_word(10'h2AA, 10'h155, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(10'h155, 10'h2AA, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    // zero degree gives one half everywhere
    write_reg(bwl_pkg::CFG_DEGREE, 11'd0);
    send_word(10'd5, 10'd900, 32'd3, -32'sd3);
    send_word(10'd128, 10'd128, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    // zero cutoff, largest order, degenerate sides
    write_reg(bwl_pkg::CFG_DEGREE, 11'd15);
    write_reg(bwl_pkg::CFG_CUTOFF, 11'd0);
    write_reg(bwl_pkg::CFG_SIDE, 11'd0);
    send_word(10'd0, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(10'd1, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(bwl_pkg::CFG_SIDE, 11'd1);
    write_reg(bwl_pkg::CFG_CUTOFF, 11'd2047);
    send_word(10'd0, 10'd1, 32'd12345, 32'd54321);
    send_word(10'd1023, 10'd1023, 32'h8000_0000, 32'h8000_0000);
    drain();
    // side above the limit is clamped; a write past the list is dropped
    write_reg(bwl_pkg::CFG_SIDE, 11'd2047);
    write_reg(CFG_UNUSED, 11'h7FF);
    write_reg(bwl_pkg::CFG_DEGREE, 11'h7F1);
    write_reg(bwl_pkg::CFG_CUTOFF, 11'd1024);
    send_word(10'd512, 10'd512, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(10'd0, 10'd0, 32'h4000_0000, 32'hC000_0000);
    send_word(10'd1023, 10'd0, 32'd99, -32'sd99);
    drain();
    write_reg(bwl_pkg::CFG_SIDE, 11'd1024);
    write_reg(bwl_pkg::CFG_CUTOFF, 11'd1);
    send_word(10'd512, 10'd512, 32'hFFFF_FFFF, 32'd1);
    send_word(10'd512, 10'd513, 32'd65535, -32'sd65535);
    drain();
  endtask

  task automatic test_random_phase(int words);
    int n_side;
    for (int i = 0; i < words; i++) begin
      if (i % 50 == 0) begin
        drain();
        case ($urandom_range(9))
          0: write_reg(bwl_pkg::CFG_SIDE, 11'($urandom_range(2047)));
          1: write_reg(bwl_pkg::CFG_SIDE, 11'($urandom_range(1)));
          default: write_reg(bwl_pkg::CFG_SIDE, 11'($urandom_range(1024, 2)));
        endcase
        n_side = (side_q > bwl_pkg::SIDE_LIMIT) ? bwl_pkg::MAX_SIDE : side_q;
        case ($urandom_range(7))
          0: write_reg(bwl_pkg::CFG_CUTOFF, 11'($urandom_range(2047)));
          1: write_reg(bwl_pkg::CFG_CUTOFF, ($urandom_range(1)) ? 11'd0 : 11'd2047);
          default: write_reg(bwl_pkg::CFG_CUTOFF, 11'($urandom_range(n_side / 2 + 1, 1)));
        endcase
        write_reg(bwl_pkg::CFG_DEGREE, 11'($urandom));
      end
      if ($urandom_range(9) == 0 || n_side < 2)
        send_word(10'($urandom), 10'($urandom), rand_part(), rand_part());
      else
        send_word(10'($urandom_range(n_side - 1)), 10'($urandom_range(n_side - 1)),
                  rand_part(), rand_part());
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_idx = bwl_pkg::CFG_DEGREE; cfg_data = '0;
    in_row = '0; in_col = '0; in_re_in = '0; in_im_in = '0;
    err_count = 0; idle_pct = 29; word_taken = 1'b0; stall_cycles = 0;
    order_q = 4'd2; cutoff_q = 11'd32; side_q = 11'd256;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phase(450);
    idle_pct = 72;
    test_random_phase(450);
    idle_pct = 0;
    test_random_phase(450);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (err_count == 0 && pending_gain.size() == 0)
      $display("butterworth_lowpass_weighting_tb: done, clean");
    else
      $display("butterworth_lowpass_weighting_tb: done, errors");
    $finish;
  end

endmodule

/* butterworth_lowpass_weighting.f */
src/bwl_pkg.sv
src/bwl_div.sv
src/butterworth_lowpass_weighting.sv
dv/butterworth_lowpass_weighting_tb.sv
